// ===== hw/rtl/bblp_pkg.sv =====
// shared constants for the box blur line pass block
package bblp_pkg;

  localparam int CHAN_W   = 16;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int RES_W    = PIX_W + 1;

  localparam int RADIUS_W = 5;
  localparam int RECIP_W  = 16;
  localparam int CFG_W    = 16;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_RECIP  = 1'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;
  localparam logic [RECIP_W-1:0]  RECIP_RESET  = 16'd21845;

  localparam int DEF_MAX_RADIUS    = 31;
  localparam int DEF_HISTORY_DEPTH = 64;
  localparam int DEF_MAX_LINE      = 4096;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

endpackage

// ===== hw/rtl/box_blur_line_pass_unit.sv =====
// top level of the box blur line pass block
// One-dimensional box filter over a line of RGBA pixels. Pixels enter one per
// clock through push/full while full is low; output i appears once input i+r
// has entered, and after the last pixel of a line (line_end_in, or the
// MAX_LINE-th pixel) the back end runs r flush steps for the remaining
// outputs, one per cycle while the result queue has room, while the short
// command queue absorbs and then stalls new pixels. So a line of n pixels
// takes n + r back-end ops. A result passes the command queue, the op
// register, the running sums, the product register and the result queue
// before it can be popped. radius is latched at the first pixel of each
// line; window_reciprocal is used as written. No clearing pass after reset.
module box_blur_line_pass_unit #(
  parameter int MAX_RADIUS    = bblp_pkg::DEF_MAX_RADIUS,
  parameter int HISTORY_DEPTH = bblp_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_LINE      = bblp_pkg::DEF_MAX_LINE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [bblp_pkg::CHAN_W-1:0]    red_in,
  input  logic [bblp_pkg::CHAN_W-1:0]    green_in,
  input  logic [bblp_pkg::CHAN_W-1:0]    blue_in,
  input  logic [bblp_pkg::CHAN_W-1:0]    alpha_in,
  input  logic                           line_end_in,
  output logic                           empty,
  input  logic                           pop,
  output logic [bblp_pkg::CHAN_W-1:0]    red_out,
  output logic [bblp_pkg::CHAN_W-1:0]    green_out,
  output logic [bblp_pkg::CHAN_W-1:0]    blue_out,
  output logic [bblp_pkg::CHAN_W-1:0]    alpha_out,
  output logic                           line_done,
  input  logic                           write_enable,
  input  logic [bblp_pkg::REG_IDX_W-1:0] write_index,
  input  logic [bblp_pkg::CFG_W-1:0]     write_data
);

  localparam int R_LIM = (MAX_RADIUS < (HISTORY_DEPTH - 2) / 2) ?
                         MAX_RADIUS : (HISTORY_DEPTH - 2) / 2;
  localparam int RW = $clog2(R_LIM + 1);
  localparam int PW = $clog2(MAX_LINE);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CMD_W = bblp_pkg::PIX_W + 1 + RW + PW + 2 * AW;
  localparam int OCW = $clog2(bblp_pkg::OUT_DEPTH + 1);
  localparam int CCW = $clog2(bblp_pkg::CMD_DEPTH + 1);

  logic [bblp_pkg::RADIUS_W-1:0] radius;
  logic [bblp_pkg::RECIP_W-1:0]  window_reciprocal;

  logic                          cmd_push;
  logic [CMD_W-1:0]              cmd_wdata;
  logic                          cmd_full;
  logic                          cmd_pop;
  logic [CMD_W-1:0]              cmd_rdata;
  logic                          cmd_empty;
  logic [CCW-1:0]                cmd_count;
  logic                          res_push;
  logic [bblp_pkg::RES_W-1:0]    res_wdata;
  logic [bblp_pkg::RES_W-1:0]    res_rdata;
  logic [OCW-1:0]                res_count;
  logic                          res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius            <= bblp_pkg::RADIUS_RESET;
      window_reciprocal <= bblp_pkg::RECIP_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        bblp_pkg::REG_RADIUS: radius <= write_data[bblp_pkg::RADIUS_W-1:0];
        bblp_pkg::REG_RECIP:  window_reciprocal <= write_data[bblp_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  bblp_front #(
    .MAX_RADIUS    (MAX_RADIUS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_LINE      (MAX_LINE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .alpha_in    (alpha_in),
    .line_end_in (line_end_in),
    .radius      (radius),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_wdata)
  );

  bblp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (bblp_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_rdata),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  bblp_back #(
    .MAX_RADIUS    (MAX_RADIUS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_LINE      (MAX_LINE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .recip     (window_reciprocal),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  bblp_fifo #(
    .WIDTH (bblp_pkg::RES_W),
    .DEPTH (bblp_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_rdata),
    .empty (empty),
    .count (res_count)
  );

  assign full      = cmd_full;
  assign red_out   = res_rdata[0 * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W];
  assign green_out = res_rdata[1 * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W];
  assign blue_out  = res_rdata[2 * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W];
  assign alpha_out = res_rdata[3 * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W];
  assign line_done = res_rdata[bblp_pkg::PIX_W];

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  a_cmd_count: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= CCW'(bblp_pkg::CMD_DEPTH))
    else $error("command queue count out of range");

endmodule

// ===== hw/rtl/bblp_ram.sv =====
// generic single-write, single-read ram with registered read data
module bblp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bblp_fifo.sv =====
// small register fifo with occupancy count
module bblp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [IW-1:0]    wptr;
  logic [IW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == IW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == IW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

endmodule

// ===== hw/rtl/bblp_front.sv =====
// front end: takes pixels, tracks line position and radius, builds commands
module bblp_front #(
  parameter int MAX_RADIUS    = bblp_pkg::DEF_MAX_RADIUS,
  parameter int HISTORY_DEPTH = bblp_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_LINE      = bblp_pkg::DEF_MAX_LINE,
  localparam int R_LIM = (MAX_RADIUS < (HISTORY_DEPTH - 2) / 2) ?
                         MAX_RADIUS : (HISTORY_DEPTH - 2) / 2,
  localparam int RW = $clog2(R_LIM + 1),
  localparam int PW = $clog2(MAX_LINE),
  localparam int AW = $clog2(HISTORY_DEPTH),
  localparam int CMD_W = bblp_pkg::PIX_W + 1 + RW + PW + 2 * AW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [bblp_pkg::CHAN_W-1:0]   red_in,
  input  logic [bblp_pkg::CHAN_W-1:0]   green_in,
  input  logic [bblp_pkg::CHAN_W-1:0]   blue_in,
  input  logic [bblp_pkg::CHAN_W-1:0]   alpha_in,
  input  logic                          line_end_in,
  input  logic [bblp_pkg::RADIUS_W-1:0] radius,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output logic [CMD_W-1:0]              cmd_data
);

  typedef struct packed {
    logic [bblp_pkg::PIX_W-1:0] pixel;
    logic                       last;
    logic [RW-1:0]              r;
    logic [PW-1:0]              p;
    logic [AW-1:0]              wa;
    logic [AW-1:0]              ra;
  } cmd_t;

  logic [PW-1:0] pos;
  logic [AW-1:0] wp;
  logic [RW-1:0] line_r;
  logic [RW-1:0] rad_sat;
  logic [RW-1:0] r_eff;
  logic [AW-1:0] span;
  logic          last;
  logic          early;
  logic [AW-1:0] ra;
  cmd_t          cmd;

  always_comb begin
    rad_sat = (32'(radius) > R_LIM) ? RW'(R_LIM) : RW'(radius);
    r_eff   = (pos == '0) ? rad_sat : line_r;
    span    = AW'({r_eff, 1'b1});
    last    = line_end_in || (pos == PW'(MAX_LINE - 1));
    early   = ((PW + AW)'(pos) < (PW + AW)'(span));
    if (early) begin
      ra = '0;
    end else if (wp >= span) begin
      ra = wp - span;
    end else begin
      ra = AW'({1'b0, wp} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, span});
    end
    cmd.pixel = {alpha_in, blue_in, green_in, red_in};
    cmd.last  = last;
    cmd.r     = r_eff;
    cmd.p     = pos;
    cmd.wa    = wp;
    cmd.ra    = ra;
  end

  assign cmd_push = push && !cmd_full;
  assign cmd_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      wp     <= '0;
      line_r <= '0;
    end else if (cmd_push) begin
      line_r <= r_eff;
      if (last) begin
        pos <= '0;
        wp  <= '0;
      end else begin
        pos <= pos + 1'b1;
        wp  <= (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bblp_back.sv =====
// back end: history ram, running sums, end-of-line flush and output scaling
module bblp_back #(
  parameter int MAX_RADIUS    = bblp_pkg::DEF_MAX_RADIUS,
  parameter int HISTORY_DEPTH = bblp_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_LINE      = bblp_pkg::DEF_MAX_LINE,
  localparam int R_LIM = (MAX_RADIUS < (HISTORY_DEPTH - 2) / 2) ?
                         MAX_RADIUS : (HISTORY_DEPTH - 2) / 2,
  localparam int RW = $clog2(R_LIM + 1),
  localparam int PW = $clog2(MAX_LINE),
  localparam int AW = $clog2(HISTORY_DEPTH),
  localparam int CMD_W = bblp_pkg::PIX_W + 1 + RW + PW + 2 * AW,
  localparam int OCW = $clog2(bblp_pkg::OUT_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_empty,
  input  logic [CMD_W-1:0]             cmd_data,
  output logic                         cmd_pop,
  input  logic [bblp_pkg::RECIP_W-1:0] recip,
  input  logic [OCW-1:0]               res_count,
  output logic                         res_push,
  output logic [bblp_pkg::RES_W-1:0]   res_data
);

  localparam int CW = $clog2(MAX_LINE + R_LIM);
  localparam int SW = bblp_pkg::CHAN_W + RW + 1;
  localparam int PRW = SW + bblp_pkg::RECIP_W;
  localparam int KW = OCW + 2;

  typedef struct packed {
    logic [bblp_pkg::PIX_W-1:0] pixel;
    logic                       last;
    logic [RW-1:0]              r;
    logic [PW-1:0]              p;
    logic [AW-1:0]              wa;
    logic [AW-1:0]              ra;
  } cmd_t;

  typedef enum logic {ST_RUN, ST_FLUSH} state_t;

  cmd_t   cmd;
  state_t st;

  logic [bblp_pkg::PIX_W-1:0] x_hold;
  logic [RW-1:0]              r_hold;
  logic [CW-1:0]              cr;
  logic [AW-1:0]              fa;
  logic [RW-1:0]              step;
  logic [AW-1:0]              span2;
  logic [AW-1:0]              fa0;

  logic                       credit;
  logic                       issue;
  logic [bblp_pkg::PIX_W-1:0] op_x;
  logic                       op_first;
  logic [RW-1:0]              op_r;
  logic                       op_emit;
  logic                       op_done;
  logic [AW-1:0]              rd_addr;
  logic                       ram_we;
  logic [bblp_pkg::PIX_W-1:0] leave;

  logic                       vb;
  logic [bblp_pkg::PIX_W-1:0] xb;
  logic                       first_b;
  logic [RW-1:0]              rb;
  logic                       emit_b;
  logic                       done_b;
  logic [SW-1:0]              sums [bblp_pkg::NUM_CHAN];

  logic                       vc;
  logic                       done_c;
  logic                       vd;
  logic                       done_d;
  logic [PRW-1:0]             prod [bblp_pkg::NUM_CHAN];

  assign cmd = cmd_t'(cmd_data);

  assign credit = (KW'(res_count) + KW'(vb && emit_b) + KW'(vc) + KW'(vd))
                  < KW'(bblp_pkg::OUT_DEPTH);

  always_comb begin
    span2 = AW'({cmd.r, 1'b0});
    if (cmd.wa >= span2) begin
      fa0 = cmd.wa - span2;
    end else begin
      fa0 = AW'({1'b0, cmd.wa} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, span2});
    end
    unique case (st)
      ST_RUN: begin
        cmd_pop  = !cmd_empty && credit;
        issue    = cmd_pop;
        op_x     = cmd.pixel;
        op_first = (cmd.p == '0);
        op_r     = cmd.r;
        op_emit  = (CW'(cmd.p) >= CW'(cmd.r));
        op_done  = cmd.last && (cmd.r == '0);
        rd_addr  = cmd.ra;
        ram_we   = cmd_pop;
      end
      ST_FLUSH: begin
        cmd_pop  = 1'b0;
        issue    = credit;
        op_x     = x_hold;
        op_first = 1'b0;
        op_r     = r_hold;
        op_emit  = (cr >= CW'(r_hold));
        op_done  = (step == r_hold);
        rd_addr  = (cr >= CW'({r_hold, 1'b1})) ? fa : '0;
        ram_we   = 1'b0;
      end
      default: begin
        cmd_pop  = 1'b0;
        issue    = 1'b0;
        op_x     = cmd.pixel;
        op_first = 1'b0;
        op_r     = cmd.r;
        op_emit  = 1'b0;
        op_done  = 1'b0;
        rd_addr  = cmd.ra;
        ram_we   = 1'b0;
      end
    endcase
  end

  bblp_ram #(
    .WIDTH (bblp_pkg::PIX_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.wa),
    .wdata (cmd.pixel),
    .raddr (rd_addr),
    .rdata (leave)
  );

  // sequencer: one op per pixel, then r flush ops after the last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RUN;
    end else begin
      unique case (st)
        ST_RUN: begin
          if (cmd_pop && cmd.last && (cmd.r != '0)) begin
            st     <= ST_FLUSH;
            x_hold <= cmd.pixel;
            r_hold <= cmd.r;
            cr     <= CW'(cmd.p) + 1'b1;
            fa     <= fa0;
            step   <= RW'(1);
          end
        end
        ST_FLUSH: begin
          if (credit) begin
            cr   <= cr + 1'b1;
            fa   <= (fa == AW'(HISTORY_DEPTH - 1)) ? '0 : fa + 1'b1;
            step <= step + 1'b1;
            if (step == r_hold) begin
              st <= ST_RUN;
            end
          end
        end
        default: st <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      vb <= issue;
      vc <= vb && emit_b;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      xb      <= op_x;
      first_b <= op_first;
      rb      <= op_r;
      emit_b  <= op_emit;
      done_b  <= op_done;
    end
    done_c <= done_b;
    done_d <= done_c;
  end

  // running window sums
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
        sums[ch] <= '0;
      end
    end else if (vb) begin
      for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
        if (first_b) begin
          sums[ch] <= SW'({rb, 1'b1})
                      * SW'(xb[ch * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W]);
        end else begin
          sums[ch] <= sums[ch]
                      + SW'(xb[ch * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W])
                      - SW'(leave[ch * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
      prod[ch] <= PRW'(sums[ch]) * PRW'(recip);
    end
  end

  always_comb begin
    res_push = vd;
    res_data[bblp_pkg::PIX_W] = done_d;
    for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
      if (prod[ch][PRW-1:bblp_pkg::CHAN_W + bblp_pkg::RECIP_W] != '0) begin
        res_data[ch * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W] = '1;
      end else begin
        res_data[ch * bblp_pkg::CHAN_W +: bblp_pkg::CHAN_W] =
          prod[ch][bblp_pkg::RECIP_W +: bblp_pkg::CHAN_W];
      end
    end
  end

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_count < OCW'(bblp_pkg::OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_ram_hazard: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && (cmd.p != '0)) |-> (cmd.ra != cmd.wa))
    else $error("history read collides with write");

  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FLUSH && issue && op_done) |=> (st == ST_RUN))
    else $error("flush did not end on its last step");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (vb && done_b) |-> emit_b)
    else $error("line end op without an output");

endmodule

// ===== bench/box_blur_line_pass_unit_tb.sv =====
// self-checking testbench for the box blur line pass unit with a predicting scoreboard
`timescale 1ns / 100ps

module box_blur_line_pass_unit_tb;

  typedef logic [bblp_pkg::NUM_CHAN-1:0][bblp_pkg::CHAN_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t chans;
    logic   done;
  } blurred_t;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 40;

  class box_blur_scoreboard;
    logic [bblp_pkg::RADIUS_W-1:0] radius_reg;
    logic [bblp_pkg::RECIP_W-1:0]  recip_reg;
    pixel_t                        history [bblp_pkg::DEF_HISTORY_DEPTH];
    int unsigned                   sums [bblp_pkg::NUM_CHAN];
    int unsigned                   in_pos;
    int unsigned                   line_r;
    blurred_t                      expected_pixels [$];
    string                         chan_name [bblp_pkg::NUM_CHAN] =
                                     '{"red_out", "green_out", "blue_out", "alpha_out"};
    int                            mismatches;
    int                            pixels_in;
    int                            pixels_checked;
    int                            lines_done;

    function new();
      radius_reg = bblp_pkg::RADIUS_RESET;
      recip_reg = bblp_pkg::RECIP_RESET;
      foreach (sums[ch]) sums[ch] = 0;
      in_pos = 0;
      line_r = 0;
      mismatches = 0;
      pixels_in = 0;
      pixels_checked = 0;
      lines_done = 0;
    endfunction

    function void write_reg(logic [bblp_pkg::REG_IDX_W-1:0] idx,
                            logic [bblp_pkg::CFG_W-1:0] data);
      if (idx == bblp_pkg::REG_RADIUS) begin
        radius_reg = data[bblp_pkg::RADIUS_W-1:0];
      end else if (idx == bblp_pkg::REG_RECIP) begin
        recip_reg = data[bblp_pkg::RECIP_W-1:0];
      end
    endfunction

    function void slide_window(pixel_t entering, pixel_t leaving);
      for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
        sums[ch] = sums[ch] + entering[ch] - leaving[ch];
      end
    endfunction

    function void form_output(logic done);
      blurred_t res;
      longint unsigned prod;
      for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
        prod = (longint'(sums[ch]) * longint'(recip_reg)) >> 16;
        res.chans[ch] = (prod > 65535) ? 16'hFFFF : 16'(prod);
      end
      res.done = done;
      expected_pixels = {expected_pixels, res};
    endfunction

    function void note_pixel(pixel_t px, logic end_flag);
      int unsigned p;
      int unsigned r;
      int unsigned cr;
      bit last;
      pixel_t leaving;
      p = in_pos;
      last = end_flag || p >= bblp_pkg::DEF_MAX_LINE - 1;
      if (p == 0) begin
        r = radius_reg;
        if (r > bblp_pkg::DEF_MAX_RADIUS) r = bblp_pkg::DEF_MAX_RADIUS;
        if (r > (bblp_pkg::DEF_HISTORY_DEPTH - 2) / 2) begin
          r = (bblp_pkg::DEF_HISTORY_DEPTH - 2) / 2;
        end
        line_r = r;
      end
      r = line_r;
      history[p % bblp_pkg::DEF_HISTORY_DEPTH] = px;
      pixels_in++;
      if (p == 0) begin
        // window starts filled with copies of the first pixel
        for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) sums[ch] = (2 * r + 1) * px[ch];
      end else begin
        leaving = history[((p >= 2 * r + 1) ? p - 2 * r - 1 : 0) % bblp_pkg::DEF_HISTORY_DEPTH];
        slide_window(px, leaving);
      end
      if (p >= r) form_output(last && r == 0);
      if (last) begin
        // flush: the last pixel is replicated past the end of the line
        for (int unsigned step = 1; step <= r; step++) begin
          cr = p + step;
          leaving = history[((cr >= 2 * r + 1) ? cr - 2 * r - 1 : 0)
                            % bblp_pkg::DEF_HISTORY_DEPTH];
          slide_window(px, leaving);
          if (cr >= r) form_output(step == r);
        end
        foreach (sums[ch]) sums[ch] = 0;
        in_pos = 0;
        lines_done++;
      end else begin
        in_pos = (p + 1) & 32'h1FFF;
      end
    endfunction

    function void check_pixel(pixel_t got, logic got_done);
      blurred_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected transaction: red_out %0d green_out %0d blue_out %0d alpha_out %0d",
               got[0], got[1], got[2], got[3]);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) begin
        if (got[ch] !== want.chans[ch]) begin
          $error("%s: expected %0d, actual %0d", chan_name[ch], want.chans[ch], got[ch]);
          mismatches++;
        end
      end
      if (got_done !== want.done) begin
        $error("line_done: expected %0d, actual %0d", want.done, got_done);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  logic [bblp_pkg::CHAN_W-1:0]    red_in = '0;
  logic [bblp_pkg::CHAN_W-1:0]    green_in = '0;
  logic [bblp_pkg::CHAN_W-1:0]    blue_in = '0;
  logic [bblp_pkg::CHAN_W-1:0]    alpha_in = '0;
  logic                           line_end_in = 1'b0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [bblp_pkg::CHAN_W-1:0]    red_out;
  logic [bblp_pkg::CHAN_W-1:0]    green_out;
  logic [bblp_pkg::CHAN_W-1:0]    blue_out;
  logic [bblp_pkg::CHAN_W-1:0]    alpha_out;
  logic                           line_done;
  logic                           write_enable = 1'b0;
  logic [bblp_pkg::REG_IDX_W-1:0] write_index = '0;
  logic [bblp_pkg::CFG_W-1:0]     write_data = '0;

  int send_idle_pct = 21;
  int recv_stall_pct = 21;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int send_idle_by_phase [4] = '{0, 80, 0, 21};
  int recv_stall_by_phase [4] = '{0, 0, 80, 21};

  box_blur_scoreboard sb;

  box_blur_line_pass_unit uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .alpha_in     (alpha_in),
    .line_end_in  (line_end_in),
    .empty        (empty),
    .pop          (pop),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out),
    .line_done    (line_done),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (write_enable) sb.write_reg(write_index, write_data);
      if (push && !full) sb.note_pixel({alpha_in, blue_in, green_in, red_in}, line_end_in);
      if (pop && !empty) sb.check_pixel({alpha_out, blue_out, green_out, red_out}, line_done);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = holds_served + 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pixel(pixel_t px, logic end_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    red_in <= px[0];
    green_in <= px[1];
    blue_in <= px[2];
    alpha_in <= px[3];
    line_end_in <= end_flag;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [bblp_pkg::CHAN_W-1:0] random_channel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return bblp_pkg::CHAN_W'($urandom);
    endcase
  endfunction

  task automatic send_line(int len);
    pixel_t px;
    for (int i = 0; i < len; i++) begin
      for (int ch = 0; ch < bblp_pkg::NUM_CHAN; ch++) px[ch] = random_channel();
      send_pixel(px, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_filter(logic [bblp_pkg::CFG_W-1:0] radius_data,
                                logic [bblp_pkg::CFG_W-1:0] recip_data);
    write_enable <= 1'b1;
    write_index <= bblp_pkg::REG_RADIUS;
    write_data <= radius_data;
    @(posedge clk);
    write_index <= bblp_pkg::REG_RECIP;
    write_data <= recip_data;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  initial begin
    int phase_items;
    int r;
    int len;
    logic [bblp_pkg::CFG_W-1:0] radius_data;
    logic [bblp_pkg::CFG_W-1:0] recip_data;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, channel extremes
    send_pixel({16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_pixel({16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0);
    send_pixel({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b1);

    // radius zero with the largest reciprocal, single pixel line
    wait_drained();
    program_filter(16'd0, 16'hFFFF);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_pixel({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE}, 1'b1);
    send_pixel({16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5}, 1'b1);

    // line shorter than window, saturated result, junk above the radius bits
    wait_drained();
    program_filter(16'hFFE5, 16'hFFFF);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_pixel({16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_pixel({16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1);

    // widest window
    wait_drained();
    program_filter(16'd31, 16'd1040);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_pixel({16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1);

    // radius changed between lines takes effect on the next line
    wait_drained();
    program_filter(16'd2, 16'd13107);
    send_line(3);
    wait_drained();
    program_filter(16'd7, 16'd0);
    send_pixel({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0);
    send_pixel({16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    send_line(2);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct <= send_idle_by_phase[ph];
      recv_stall_pct <= recv_stall_by_phase[ph];
      phase_items = 0;
      if (ph == 0) begin
        wait_drained();
        program_filter(16'd1, bblp_pkg::RECIP_RESET);
        hold_requests <= hold_requests + 1;
        send_line(48);
      end
      while (phase_items < PHASE_ITEMS) begin
        wait_drained();
        case ($urandom_range(19))
          0: r = 0;
          1: r = 31;
          2: r = $urandom_range(16, 31);
          default: r = $urandom_range(1, 8);
        endcase
        radius_data = bblp_pkg::CFG_W'(r);
        if ($urandom_range(3) == 0) begin
          radius_data[bblp_pkg::CFG_W-1:bblp_pkg::RADIUS_W] =
            (bblp_pkg::CFG_W - bblp_pkg::RADIUS_W)'($urandom);
        end
        case ($urandom_range(9))
          0: recip_data = 16'hFFFF;
          1: recip_data = 16'h0000;
          2: recip_data = bblp_pkg::CFG_W'($urandom);
          default: recip_data = (r == 0) ? 16'hFFFF : bblp_pkg::CFG_W'(65536 / (2 * r + 1));
        endcase
        program_filter(radius_data, recip_data);
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(9))
            0: len = $urandom_range(1, r + 1);
            1: len = 1;
            default: len = $urandom_range(r + 1, 2 * r + 24);
          endcase
          send_line(len);
          phase_items += len;
        end
      end
    end

    wait_drained();
    $display("filtered %0d pixels in %0d lines, %0d results checked",
             sb.pixels_in, sb.lines_done, sb.pixels_checked);
    $display("radius 0 to 31, zero and saturating reciprocals, short lines, stalls");
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== box_blur_line_pass_unit.f =====
hw/rtl/bblp_pkg.sv
hw/rtl/bblp_ram.sv
hw/rtl/bblp_fifo.sv
hw/rtl/bblp_front.sv
hw/rtl/bblp_back.sv
hw/rtl/box_blur_line_pass_unit.sv
bench/box_blur_line_pass_unit_tb.sv
